/* rtl/core/xgec_pkg.sv */
// Package for the 3x3 XOR grid erasure codec: shard indexes, grid layout,
// per-shard recovery recipes and the functions that build them.
// No dependencies; used by the interfaces, the top level and the checker.
package xgec_pkg;

  localparam int NumShards     = 9;
  localparam int NumDataShards = 4;
  localparam int NumParShards  = 5;
  localparam int NumRounds     = 9;
  localparam logic [7:0] LINE_MARK = 8'h80;

  // Configuration register indexes.
  localparam logic REG_MODE    = 1'b0;
  localparam logic REG_PRESENT = 1'b1;

  // Mode codes.
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [NumShards-1:0] PRESENT_RESET = 9'h1FF;

  typedef logic [3:0] shard_idx_t;
  typedef logic [3:0] round_cnt_t;

  // Grid rows; columns are read down the same table.
  localparam shard_idx_t GRID [3][3] = '{
    '{4'd0, 4'd1, 4'd4},
    '{4'd3, 4'd2, 4'd6},
    '{4'd7, 4'd5, 4'd8}
  };

  // How one output shard is formed: the XOR of the input shards in src,
  // plus the line mark when mark is set. An unknown shard has no sources.
  typedef struct packed {
    logic                 known;
    logic [NumShards-1:0] src;
    logic                 mark;
  } shard_rcp_t;

  typedef shard_rcp_t [NumShards-1:0] rcp_vec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PEEL
  } bld_state_t;

  // Fixed recipes for encode: data passes through, parity from data.
  function automatic rcp_vec_t encode_recipe();
    rcp_vec_t r;
    for (int k = 0; k < NumShards; k++) begin
      r[k].known = 1'b1;
      r[k].src   = '0;
      r[k].mark  = 1'b1;
    end
    for (int k = 0; k < NumDataShards; k++) begin
      r[k].src[k] = 1'b1;
      r[k].mark   = 1'b0;
    end
    r[4].src = 9'b0_0000_0011;
    r[5].src = 9'b0_0000_0110;
    r[6].src = 9'b0_0000_1100;
    r[7].src = 9'b0_0000_1001;
    r[8].src = 9'b0_0000_1111;
    return r;
  endfunction

  // Starting recipes for decode: present shards stand for themselves.
  function automatic rcp_vec_t decode_init(logic [NumShards-1:0] present);
    rcp_vec_t r;
    for (int k = 0; k < NumShards; k++) begin
      r[k].known  = present[k];
      r[k].src    = '0;
      r[k].src[k] = present[k];
      r[k].mark   = 1'b0;
    end
    return r;
  endfunction

  // Fill the single unknown member of one line, if there is exactly one.
  function automatic rcp_vec_t fill_line(rcp_vec_t r, shard_idx_t a, shard_idx_t b,
                                         shard_idx_t c);
    shard_idx_t           m [3];
    logic [1:0]           miss;
    shard_idx_t           slot;
    logic [NumShards-1:0] acc_src;
    logic                 acc_mark;
    rcp_vec_t             q;
    m[0]     = a;
    m[1]     = b;
    m[2]     = c;
    miss     = 2'd0;
    slot     = a;
    acc_src  = '0;
    acc_mark = 1'b1;
    q        = r;
    for (int i = 0; i < 3; i++) begin
      if (!r[m[i]].known) begin
        miss = miss + 2'd1;
        slot = m[i];
      end else begin
        acc_src  = acc_src ^ r[m[i]].src;
        acc_mark = acc_mark ^ r[m[i]].mark;
      end
    end
    if (miss == 2'd1) begin
      q[slot].known = 1'b1;
      q[slot].src   = acc_src;
      q[slot].mark  = acc_mark;
    end
    return q;
  endfunction

  // One peeling round: row j then column j, for j from 0 to 2.
  function automatic rcp_vec_t peel_round(rcp_vec_t r);
    rcp_vec_t q;
    q = r;
    for (int j = 0; j < 3; j++) begin
      q = fill_line(q, GRID[j][0], GRID[j][1], GRID[j][2]);
      q = fill_line(q, GRID[0][j], GRID[1][j], GRID[2][j]);
    end
    return q;
  endfunction

endpackage

/* rtl/core/xgec_if.sv */
// Channel interfaces for the XOR grid erasure codec: input items, results
// and configuration writes. Depends on xgec_pkg for the shard counts.
interface xgec_item_if
  import xgec_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic [8*NumDataShards-1:0] data_bytes;
  logic [8*NumParShards-1:0]  parity_bytes;

  modport source (output valid, output data_bytes, output parity_bytes, input ready);
  modport sink   (input valid, input data_bytes, input parity_bytes, output ready);
endinterface

interface xgec_result_if
  import xgec_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic [8*NumDataShards-1:0] data_out;
  logic [8*NumParShards-1:0]  parity_out;
  logic                       recovered;

  modport source (output valid, output data_out, output parity_out, output recovered,
                  input ready);
  modport sink   (input valid, input data_out, input parity_out, input recovered,
                  output ready);
endinterface

interface xgec_cfg_if
  import xgec_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic                 index;
  logic [NumShards-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/xor_grid_erasure_codec.sv */
// XOR grid erasure codec, top level: recipe builder and two-stage datapath.
// Depends on xgec_pkg and the channel interfaces in xgec_if.sv.
//
// Usage:
//   item   - one byte-column per word: four data bytes and five parity bytes.
//   result - nine bytes after encode or recovery, plus the recovered flag.
//   cfg    - register writes: index 0 is the mode (0 encode, 1 decode),
//            index 1 the mask of present shards. Always ready.
// Every line of the 3x3 grid XORs to 0x80. Which shards can be rebuilt, and
// from which inputs, depends only on the mode and the mask, so after reset
// and after every register write a small builder works out one recipe per
// shard: a load step, then one peeling round per cycle, at most nine.
// The item channel is held not ready while the builder runs.
// After that one word is taken every cycle while the result side does not stall.
// An accepted word sits in an input register, then the XOR network chosen by
// the recipes feeds the result register. A stalled result holds in its
// register while the input register still takes one more word; input ready
// falls only when both are full. Reset is synchronous: both stages empty,
// mode encode, all shards present, and the builder runs once.
module xor_grid_erasure_codec
  import xgec_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  xgec_item_if.sink          item,
  xgec_result_if.source      result,
  xgec_cfg_if.sink           cfg
);

  logic                 mode;
  logic [NumShards-1:0] present;
  bld_state_t           state, state_next;
  round_cnt_t           round, round_next;
  rcp_vec_t             rcp, rcp_next;
  logic                 data_known;
  logic                 cfg_write;

  logic                 s1_valid;
  logic [7:0]           s1_byte [NumShards];
  logic                 s2_free;
  logic                 item_take;
  logic [7:0]           shard_out [NumShards];

  // Configuration registers.
  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_ENCODE;
      present <= PRESENT_RESET;
    end else if (cfg_write) begin
      unique case (cfg.index)
        REG_MODE:    mode    <= cfg.data[0];
        REG_PRESENT: present <= cfg.data;
        default:     mode    <= mode;
      endcase
    end
  end

  // All four data shards have a recipe.
  always_comb begin
    data_known = 1'b1;
    for (int k = 0; k < NumDataShards; k++) begin
      data_known = data_known && rcp[k].known;
    end
  end

  // Recipe builder: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: state_next = ST_IDLE;
      ST_LOAD: state_next = (mode == MODE_ENCODE) ? ST_IDLE : ST_PEEL;
      ST_PEEL: begin
        if (data_known || round == round_cnt_t'(NumRounds)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_LOAD;
    endcase
    if (cfg_write) begin
      state_next = ST_LOAD;
    end
  end

  // Recipe builder: recipe and round updates.
  always_comb begin
    rcp_next   = rcp;
    round_next = round;
    unique case (state)
      ST_IDLE: rcp_next = rcp;
      ST_LOAD: begin
        round_next = '0;
        rcp_next   = (mode == MODE_ENCODE) ? encode_recipe() : decode_init(present);
      end
      ST_PEEL: begin
        if (!data_known && round != round_cnt_t'(NumRounds)) begin
          rcp_next   = peel_round(rcp);
          round_next = round + round_cnt_t'(1);
        end
      end
      default: rcp_next = rcp;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      round <= '0;
    end else begin
      state <= state_next;
      round <= round_next;
    end
    rcp <= rcp_next;
  end

  // Handshake: the result register frees when empty or taken.
  assign s2_free    = !result.valid || result.ready;
  assign item.ready = (state == ST_IDLE) && (!s1_valid || s2_free);
  assign item_take  = item.valid && item.ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_take) begin
      s1_valid <= 1'b1;
    end else if (s2_free) begin
      s1_valid <= 1'b0;
    end
    if (item_take) begin
      for (int k = 0; k < NumDataShards; k++) begin
        s1_byte[k] <= item.data_bytes[8*k +: 8];
      end
      for (int k = 0; k < NumParShards; k++) begin
        s1_byte[NumDataShards+k] <= item.parity_bytes[8*k +: 8];
      end
    end
  end

  // XOR network: each shard is its recipe's sources plus the line mark.
  always_comb begin
    for (int k = 0; k < NumShards; k++) begin
      shard_out[k] = rcp[k].mark ? LINE_MARK : 8'h00;
      for (int i = 0; i < NumShards; i++) begin
        if (rcp[k].src[i]) begin
          shard_out[k] = shard_out[k] ^ s1_byte[i];
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s2_free) begin
      result.valid <= s1_valid;
    end
    if (s2_free && s1_valid) begin
      for (int k = 0; k < NumDataShards; k++) begin
        result.data_out[8*k +: 8] <= shard_out[k];
      end
      for (int k = 0; k < NumParShards; k++) begin
        result.parity_out[8*k +: 8] <= shard_out[NumDataShards+k];
      end
      result.recovered <= data_known;
    end
  end

endmodule

/* rtl/core/xgec_checker.sv */
// Port-level checker for the XOR grid erasure codec, and its bind.
// Depends on xgec_pkg; attached to xor_grid_erasure_codec below.
module xgec_checker
  import xgec_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       item_ready,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic [8*NumDataShards-1:0] res_data,
  input logic [8*NumParShards-1:0]  res_parity,
  input logic                       res_recovered
);

  // A stalled result word keeps its payload.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data) &&
                                $stable(res_parity) && $stable(res_recovered))
    else $error("result word changed while stalled");

  // A register write restarts the recipe build, so no word is taken next.
  a_cfg_rebuild: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !item_ready)
    else $error("item taken right after a register write");

  // Reset empties the result register and holds the item channel.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid && !item_ready)
    else $error("result or ready active after reset");

endmodule

bind xor_grid_erasure_codec xgec_checker u_xgec_checker (
  .clk           (clk),
  .rst           (rst),
  .item_ready    (item.ready),
  .cfg_valid     (cfg.valid),
  .cfg_ready     (cfg.ready),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .res_data      (result.data_out),
  .res_parity    (result.parity_out),
  .res_recovered (result.recovered)
);

/* sim/xor_grid_erasure_codec_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the 3x3 XOR grid erasure codec: random bursts of
// byte-columns checked against a behavioral predictor. Needs xgec_pkg and xgec_if.sv.
module xor_grid_erasure_codec_tb;
  import xgec_pkg::*;

  localparam int RandomWords = 1900;
  localparam int HoldAfter   = 700;
  localparam int HoldCycles  = 300;
  localparam int CycleLimit  = 400000;
  localparam int ReportLimit = 10;

  // One input word, shard k at bits 8k+7 down to 8k.
  typedef struct packed {
    logic [8*NumParShards-1:0]  parity;
    logic [8*NumDataShards-1:0] data;
  } column_word_t;

  typedef struct packed {
    logic [8*NumDataShards-1:0] data;
    logic [8*NumParShards-1:0]  parity;
    logic                       recovered;
  } column_result_t;

  logic clk;
  logic rst = 1'b1;

  // Values driven onto the channels, known from time zero.
  logic                       item_valid  = 1'b0;
  logic [8*NumDataShards-1:0] item_data   = '0;
  logic [8*NumParShards-1:0]  item_parity = '0;
  logic                       result_ready = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_index = REG_MODE;
  logic [NumShards-1:0]       cfg_data  = '0;

  // Register contents as the block should see them.
  logic                 codec_mode = MODE_ENCODE;
  logic [NumShards-1:0] shard_mask = PRESENT_RESET;

  column_word_t   pending_columns[$];
  column_result_t expected_columns[$];

  int words_accepted = 0;
  int words_queued   = 0;
  int words_checked  = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int burst_left     = 1;
  int gap_left       = 0;
  int stall_style    = 0;
  int style_left     = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;

  xgec_item_if   item_ch ();
  xgec_result_if result_ch ();
  xgec_cfg_if    cfg_ch ();

  assign item_ch.valid        = item_valid;
  assign item_ch.data_bytes   = item_data;
  assign item_ch.parity_bytes = item_parity;
  assign result_ch.ready      = result_ready;
  assign cfg_ch.valid         = cfg_valid;
  assign cfg_ch.index         = cfg_index;
  assign cfg_ch.data          = cfg_data;

  xor_grid_erasure_codec DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Expected result for one column under the given mode and mask.
  function automatic column_result_t predict_column(logic mode, logic [NumShards-1:0] mask,
                                                    column_word_t word);
    logic [7:0]           shard [NumShards];
    logic [NumShards-1:0] known;
    shard_idx_t           member;
    shard_idx_t           gap_slot;
    logic [7:0]           acc;
    int                   missing;
    column_result_t       res;
    for (int k = 0; k < NumShards; k++) shard[k] = word[8*k +: 8];
    if (mode == MODE_ENCODE) begin
      shard[4] = shard[0] ^ shard[1] ^ LINE_MARK;
      shard[5] = shard[1] ^ shard[2] ^ LINE_MARK;
      shard[6] = shard[2] ^ shard[3] ^ LINE_MARK;
      shard[7] = shard[3] ^ shard[0] ^ LINE_MARK;
      shard[8] = shard[4] ^ shard[6] ^ LINE_MARK;
      known = '1;
    end else begin
      known = mask;
      for (int k = 0; k < NumShards; k++) if (!known[k]) shard[k] = '0;
      // Peel rows and columns until the data shards are complete.
      for (int round = 0; round < NumRounds; round++) begin
        if (known[3:0] != 4'hF) begin
          for (int j = 0; j < 3; j++) begin
            for (int axis = 0; axis < 2; axis++) begin
              missing  = 0;
              acc      = LINE_MARK;
              gap_slot = '0;
              for (int i = 0; i < 3; i++) begin
                member = (axis == 0) ? GRID[j][i] : GRID[i][j];
                if (!known[member]) begin
                  missing++;
                  gap_slot = member;
                end else begin
                  acc = acc ^ shard[member];
                end
              end
              if (missing == 1) begin
                shard[gap_slot] = acc;
                known[gap_slot] = 1'b1;
              end
            end
          end
        end
      end
    end
    res.data      = {shard[3], shard[2], shard[1], shard[0]};
    res.parity    = {shard[8], shard[7], shard[6], shard[5], shard[4]};
    res.recovered = (mode == MODE_ENCODE) || (known[3:0] == 4'hF);
    return res;
  endfunction

  // Random column, now and then all zeros or all ones; as a codeword if asked.
  function automatic column_word_t fresh_column(bit as_codeword);
    column_word_t   word;
    column_result_t enc;
    int             pick;
    pick = $urandom_range(0, 29);
    if (pick == 0) begin
      word = '0;
    end else if (pick == 1) begin
      word = '1;
    end else begin
      word.data   = $urandom;
      word.parity = {8'($urandom), $urandom};
    end
    if (as_codeword) begin
      enc         = predict_column(MODE_ENCODE, PRESENT_RESET, word);
      word.parity = enc.parity;
    end
    return word;
  endfunction

  // Append one word to the driver's queue and count it.
  task automatic queue_column(column_word_t word);
    pending_columns.insert(pending_columns.size(), word);
    words_queued++;
  endtask

  // Register writes; only called while the block is idle.
  task automatic configure(logic mode, logic [NumShards-1:0] mask, bit with_mask);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_data  <= {{(NumShards-1){1'b0}}, mode};
    do @(posedge clk); while (!cfg_ch.ready);
    codec_mode = mode;
    if (with_mask) begin
      cfg_index <= REG_PRESENT;
      cfg_data  <= mask;
      do @(posedge clk); while (!cfg_ch.ready);
      shard_mask = mask;
    end
    cfg_valid <= 1'b0;
  endtask

  // Let the queued words go out and every result come back.
  task automatic run_phase();
    do @(posedge clk);
    while (words_checked != words_queued);
    repeat (3) @(posedge clk);
  endtask

  // Item driver: bursts of words with random gaps, prediction at acceptance.
  always @(posedge clk) begin : item_driver
    column_word_t word;
    if (rst) begin
      item_valid <= 1'b0;
      burst_left <= 1;
      gap_left   <= 0;
    end else begin
      if (item_valid && item_ch.ready) begin
        expected_columns.insert(expected_columns.size(),
                                predict_column(codec_mode, shard_mask,
                                               {item_parity, item_data}));
        words_accepted <= words_accepted + 1;
      end
      if (!item_valid || item_ch.ready) begin
        if (gap_left != 0) begin
          item_valid <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (pending_columns.size() != 0) begin
          word = pending_columns.pop_front();
          item_valid  <= 1'b1;
          item_data   <= word.data;
          item_parity <= word.parity;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            if ($urandom_range(0, 2) == 0) gap_left <= 0;
            else if ($urandom_range(0, 7) == 0) gap_left <= $urandom_range(7, 20);
            else gap_left <= $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // One long hold-off on the result side, once enough words have gone in.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_accepted >= HoldAfter) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result ready follows a stall style that changes every so often.
  always @(posedge clk) begin : result_stall
    bit open;
    case (stall_style)
      0:       open = 1'b1;
      1:       open = ($urandom_range(0, 1) == 1);
      2:       open = (cycle_count % 6) < 3;
      default: open = ($urandom_range(0, 3) == 0);
    endcase
    if (rst) begin
      result_ready <= 1'b0;
      style_left   <= 0;
    end else begin
      result_ready <= open && (hold_left == 0);
      if (style_left == 0) begin
        stall_style <= $urandom_range(0, 3);
        style_left  <= $urandom_range(16, 200);
      end else begin
        style_left <= style_left - 1;
      end
    end
  end

  // Result checker: each accepted word against the oldest expectation.
  always @(posedge clk) begin : result_monitor
    column_result_t got;
    column_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.data      = result_ch.data_out;
      got.parity    = result_ch.parity_out;
      got.recovered = result_ch.recovered;
      words_checked++;
      if (expected_columns.size() == 0) begin
        if (mismatch_count < ReportLimit)
          $display("unexpected word: data %h parity %h recovered %b",
                   got.data, got.parity, got.recovered);
        mismatch_count++;
      end else begin
        want = expected_columns.pop_front();
        if (got.data !== want.data || got.parity !== want.parity ||
            got.recovered !== want.recovered) begin
          if (mismatch_count < ReportLimit)
            $display("mismatch: expected data %h parity %h recovered %b, got %h %h %b",
                     want.data, want.parity, want.recovered,
                     got.data, got.parity, got.recovered);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL xor_grid_erasure_codec");
      $finish;
    end
  end

  initial begin : stimulus
    column_word_t         word;
    logic                 mode;
    logic [NumShards-1:0] mask;
    int                   queued;
    int                   phase_len;
    int                   pick;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Encode: field extremes; incoming parity is ignored.
    configure(MODE_ENCODE, PRESENT_RESET, 1'b1);
    queue_column('0);
    queue_column('1);
    queue_column({40'h00_FFFF_0000, 32'h8080_8080});
    queue_column(fresh_column(1'b0));
    run_phase();

    // Decode with everything present: inconsistent shards pass unchanged.
    configure(MODE_DECODE, 9'h1FF, 1'b1);
    queue_column(fresh_column(1'b0));
    queue_column('1);
    queue_column(fresh_column(1'b1));
    run_phase();

    // Nothing present: all zero and not recovered.
    configure(MODE_DECODE, 9'h000, 1'b1);
    queue_column('1);
    queue_column(fresh_column(1'b1));
    run_phase();

    // One data shard lost.
    configure(MODE_DECODE, 9'h1FE, 1'b1);
    queue_column(fresh_column(1'b1));
    run_phase();

    // Data complete, so a missing parity shard stays zero.
    configure(MODE_DECODE, 9'h0FF, 1'b1);
    queue_column(fresh_column(1'b1));
    run_phase();

    // Two data shards of one row lost: a column fills each.
    configure(MODE_DECODE, 9'h1FC, 1'b1);
    queue_column(fresh_column(1'b1));
    run_phase();

    // Losses that need a second peeling round.
    configure(MODE_DECODE, 9'h1E4, 1'b1);
    queue_column(fresh_column(1'b1));
    queue_column(fresh_column(1'b1));
    run_phase();

    // All data lost, only parity present: not recoverable.
    configure(MODE_DECODE, 9'h1F0, 1'b1);
    queue_column(fresh_column(1'b1));
    run_phase();

    // Random phases: mostly decode of codewords with a few erasures.
    queued = 0;
    while (queued < RandomWords) begin
      mode = ($urandom_range(0, 4) == 0) ? MODE_ENCODE : MODE_DECODE;
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
        mask = PRESENT_RESET;
      end else if (pick < 5) begin
        mask = 9'($urandom);
      end else if (pick == 5) begin
        mask = '0;
      end else begin
        mask = PRESENT_RESET;
        repeat ($urandom_range(1, 4)) mask[$urandom_range(0, NumShards-1)] = 1'b0;
      end
      configure(mode, mask, (mode == MODE_DECODE) || ($urandom_range(0, 1) == 1));
      phase_len = $urandom_range(30, 140);
      for (int n = 0; n < phase_len; n++) begin
        if (mode == MODE_ENCODE) begin
          word = fresh_column(1'b0);
        end else begin
          pick = $urandom_range(0, 19);
          word = fresh_column(pick < 17);
          // A flipped bit in a codeword now and then.
          if (pick == 17) word = word ^ (72'd1 << $urandom_range(0, 71));
          // Erased shards carry junk half of the time.
          for (int k = 0; k < NumShards; k++)
            if (!shard_mask[k] && $urandom_range(0, 1) == 1) word[8*k +: 8] = 8'($urandom);
        end
        queue_column(word);
      end
      queued += phase_len;
      run_phase();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_columns.size() == 0) begin
      $display("PASS xor_grid_erasure_codec");
    end else begin
      $display("FAIL xor_grid_erasure_codec");
    end
    $finish;
  end

endmodule
